[rtl/lsce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_pkg: shared constants and types for the line sensor centroid core
// Weight tables, field widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lsce_pkg;

  // Sensor array and field widths
  localparam int SENSOR_COUNT = 8;
  localparam int SUM_W        = 16;
  localparam int CNT_W        = 4;
  localparam int ERR_W        = 13;
  localparam int S_TDATA_W    = 8;
  localparam int M_TDATA_W    = 16;

  // Radix-4 divide: two quotient bits per step over a SUM_W-bit dividend
  localparam int DIV_STEPS    = SUM_W / 2;
  localparam int STEP_W       = $clog2(DIV_STEPS);
  localparam int REM_W        = 3;

  // Mode codes
  localparam logic MODE_LINEAR    = 1'b0;
  localparam logic MODE_SYMMETRIC = 1'b1;

  // Pattern with no sensor on the line
  localparam logic [SENSOR_COUNT-1:0] ALL_WHITE = 8'hFF;

  // Centre offset of the linear weights and the lost-line codes
  localparam logic signed [SUM_W-1:0] CENTRE_VALUE = 16'sd3500;
  localparam logic signed [SUM_W-1:0] LOST_SYM_ERR = -16'sd1;

  // Per-sensor weights, sensor 0 first
  localparam logic signed [SUM_W-1:0] LIN_WEIGHT [SENSOR_COUNT] = '{
    16'sd0, 16'sd1000, 16'sd2000, 16'sd3000,
    16'sd4000, 16'sd5000, 16'sd6000, 16'sd7000
  };
  localparam logic signed [SUM_W-1:0] SYM_WEIGHT [SENSOR_COUNT] = '{
    -16'sd250, -16'sd130, -16'sd65, -16'sd30,
    16'sd30, 16'sd65, 16'sd130, 16'sd250
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new pattern, form sum and count
    logic step;    // run one radix-4 divide step
    logic commit;  // form the error and load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic lost;    // captured pattern saw no line
  } sts_t;

endpackage

[rtl/lsce_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_dp: datapath of the line sensor centroid core
// Forms the weighted sum and sensor count, divides the magnitude by the
// count two bits a step, then applies sign, centre and the lost-line rules.
// ----------------------------------------------------------------------------
module lsce_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                weight_mode_we,
  input  logic                                weight_mode_wdata,
  input  logic [lsce_pkg::S_TDATA_W-1:0]      s_tdata,
  input  lsce_pkg::cmd_t                      cmd,
  output lsce_pkg::sts_t                      sts,
  output logic [lsce_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tuser
);

  logic                                 weight_mode;
  logic                                 last_pos;
  logic                                 lost;
  logic                                 neg;
  logic [lsce_pkg::CNT_W-1:0]           den;
  logic [lsce_pkg::REM_W-1:0]           rem;
  logic [lsce_pkg::SUM_W-1:0]           quo;
  logic [lsce_pkg::ERR_W-1:0]           out_err;
  logic                                 out_lost;

  logic signed [lsce_pkg::SUM_W-1:0]    sum_in;
  logic [lsce_pkg::CNT_W-1:0]           cnt_in;
  logic [lsce_pkg::SUM_W-1:0]           mag_in;
  logic [lsce_pkg::REM_W-1:0]           rem_next;
  logic [lsce_pkg::SUM_W-1:0]           quo_next;
  logic signed [lsce_pkg::SUM_W-1:0]    res;

  // Weighted sum and count of black sensors in the incoming pattern
  always_comb begin
    sum_in = '0;
    cnt_in = '0;
    for (int i = 0; i < lsce_pkg::SENSOR_COUNT; i++) begin
      if (!s_tdata[i]) begin
        if (weight_mode == lsce_pkg::MODE_SYMMETRIC) begin
          sum_in = sum_in + lsce_pkg::SYM_WEIGHT[i];
        end else begin
          sum_in = sum_in + lsce_pkg::LIN_WEIGHT[i];
        end
        cnt_in = cnt_in + lsce_pkg::CNT_W'(1);
      end
    end
    mag_in = sum_in[lsce_pkg::SUM_W-1] ? lsce_pkg::SUM_W'(-sum_in) : lsce_pkg::SUM_W'(sum_in);
  end

  // Two restoring divide steps; quotient bits shift in from the bottom
  always_comb begin
    logic [lsce_pkg::REM_W:0] rem_sh;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < 2; k++) begin
      rem_sh   = {rem_next, quo_next[lsce_pkg::SUM_W-1]};
      quo_next = {quo_next[lsce_pkg::SUM_W-2:0], 1'b0};
      if (rem_sh >= den) begin
        rem_sh      = rem_sh - den;
        quo_next[0] = 1'b1;
      end
      rem_next = rem_sh[lsce_pkg::REM_W-1:0];
    end
  end

  // Signed result with centre and lost-line handling
  always_comb begin
    logic signed [lsce_pkg::SUM_W-1:0] q_s;
    q_s = neg ? -$signed(quo) : $signed(quo);
    if (lost) begin
      if (weight_mode == lsce_pkg::MODE_SYMMETRIC) begin
        res = lsce_pkg::LOST_SYM_ERR;
      end else if (last_pos) begin
        res = lsce_pkg::CENTRE_VALUE;
      end else begin
        res = -lsce_pkg::CENTRE_VALUE;
      end
    end else if (weight_mode == lsce_pkg::MODE_LINEAR) begin
      res = q_s - lsce_pkg::CENTRE_VALUE;
    end else begin
      res = q_s;
    end
  end

  // Control registers: mode and last direction
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= lsce_pkg::MODE_LINEAR;
      last_pos    <= 1'b0;
    end else begin
      if (weight_mode_we) begin
        weight_mode <= weight_mode_wdata;
      end
      if (cmd.commit && !lost && weight_mode == lsce_pkg::MODE_LINEAR) begin
        last_pos <= !res[lsce_pkg::SUM_W-1] && (res != '0);
      end
    end
  end

  // Working and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lost <= (s_tdata == lsce_pkg::ALL_WHITE);
      neg  <= sum_in[lsce_pkg::SUM_W-1];
      den  <= cnt_in;
      rem  <= '0;
      quo  <= mag_in;
    end else if (cmd.step) begin
      rem  <= rem_next;
      quo  <= quo_next;
    end
    if (cmd.commit) begin
      out_err  <= res[lsce_pkg::ERR_W-1:0];
      out_lost <= lost;
    end
  end

  assign sts.lost = lost;
  assign m_tdata  = {{(lsce_pkg::M_TDATA_W - lsce_pkg::ERR_W){1'b0}}, out_err};
  assign m_tuser  = out_lost;

endmodule

[rtl/lsce_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_ctrl: controller of the line sensor centroid core
// Sequences load, divide steps and commit, and owns the output valid flag.
// ----------------------------------------------------------------------------
module lsce_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  lsce_pkg::sts_t  sts,
  output lsce_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [lsce_pkg::STEP_W-1:0]  step_cnt;
  logic                         out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Decode commands and the next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.lost) begin
          state_next = ST_FIX;
        end else begin
          cmd.step = 1'b1;
          if (step_cnt == lsce_pkg::STEP_W'(lsce_pkg::DIV_STEPS - 1)) begin
            state_next = ST_FIX;
          end
        end
      end
      ST_FIX: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state, step count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        step_cnt <= '0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + lsce_pkg::STEP_W'(1);
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/line_sensor_centroid_error_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_centroid_error_core: line offset from an 8-sensor pattern
// Weighted centroid of the sensors that see the line, with lost-line rules.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_* carry one 8-bit pattern (bit i low = sensor i sees
//   the line). Output beats on m_* carry the signed 13-bit line error in
//   m_tdata[12:0] and the lost flag in m_tuser.
//   weight_mode_we/weight_mode_wdata write the mode register (0 = linear
//   weights minus centre with direction hold, 1 = symmetric weights); write
//   it only while no beat is in flight.
// Sequencing:
//   One beat is processed at a time. A found line takes 8 radix-4 divide
//   steps of the divider, then a commit that loads the output register;
//   the next input beat is taken only after that commit. A lost line
//   skips the divide steps and goes straight to the commit.
// Reset and stall:
//   rst clears the mode to 0, the held direction to negative, and the
//   output valid. While m_tready is low a finished result waits in the
//   output register; the next input beat is still taken and processed,
//   and its commit waits until the output register is free.
// ----------------------------------------------------------------------------
module line_sensor_centroid_error_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                weight_mode_we,
  input  logic                                weight_mode_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lsce_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] sensor_bits
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lsce_pkg::M_TDATA_W-1:0]      m_tdata,   // [12:0] line_error, [15:13] zero
  output logic                                m_tuser    // [0] line_lost
);

  lsce_pkg::cmd_t cmd;
  lsce_pkg::sts_t sts;

  lsce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsce_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .weight_mode_we    (weight_mode_we),
    .weight_mode_wdata (weight_mode_wdata),
    .s_tdata           (s_tdata),
    .cmd               (cmd),
    .sts               (sts),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser)
  );

endmodule

[rtl/lsce_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_checker: port-level checks for the line sensor centroid core
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lsce_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [lsce_pkg::M_TDATA_W-1:0]      m_tdata,
  input logic                                m_tuser
);

  // Stalled output beat stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  // Stalled output beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // Busy after taking a pattern
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken back to back");

  // Lost line reports only the full-scale or symmetric lost codes
  a_lost_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata == 16'h0DAC) || (m_tdata == 16'h1254) || (m_tdata == 16'h1FFF))
    else $error("bad lost-line error code");

  // Reset leaves no output and an open input
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output or input not idle after reset");

endmodule

bind line_sensor_centroid_error_core lsce_checker u_lsce_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/line_sensor_centroid_error_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_centroid_error_core_tb: self-checking bench for the centroid core
// A queue-fed driver sends sensor patterns in bursts with random gaps. A
// monitor stalls the result side on changing patterns and checks each result
// beat against the line offset that a local predictor computes. Both weight
// modes are run. Directed patterns cover the edge cases, and random line-like
// patterns with noise follow.
// ----------------------------------------------------------------------------
module line_sensor_centroid_error_core_tb;

  localparam int CLK_HALF   = 6;
  localparam int CENTRE_OFS = 3500;
  localparam int PAD_CYCLES = 24;

  typedef struct packed {
    logic signed [12:0] line_error;
    logic               line_lost;
  } line_pos_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PERIODIC,
    RDY_SPARSE
  } ready_kind_t;

  // Weight tables for the two modes, sensor 0 first
  int lin_w [8] = '{0, 1000, 2000, 3000, 4000, 5000, 6000, 7000};
  int sym_w [8] = '{-250, -130, -65, -30, 30, 65, 130, 250};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       weight_mode_we = 1'b0;
  logic       weight_mode_wdata = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [lsce_pkg::M_TDATA_W-1:0] m_tdata;
  logic       m_tuser;

  // Predictor state: mode register copy and held direction
  logic cur_mode = lsce_pkg::MODE_LINEAR;
  logic dir_positive = 1'b0;

  logic [7:0]  pattern_q [$];
  line_pos_t   line_pos_q [$];
  int          mismatch_count = 0;
  logic        quiet_run = 1'b0;

  int          burst_left = 0;
  int          gap_left = 0;
  ready_kind_t ready_kind = RDY_ALWAYS;
  int          ready_cnt = 0;
  line_pos_t   want;

  line_sensor_centroid_error_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .weight_mode_we    (weight_mode_we),
    .weight_mode_wdata (weight_mode_wdata),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // Compute the line offset for one pattern and advance the held direction
  function automatic line_pos_t predict_line_pos(input logic [7:0] bits);
    line_pos_t r;
    int wsum;
    int nblack;
    int pos;
    wsum   = 0;
    nblack = 0;
    r.line_lost = (bits == lsce_pkg::ALL_WHITE);
    if (r.line_lost) begin
      if (cur_mode == lsce_pkg::MODE_LINEAR) begin
        r.line_error = dir_positive ? 13'sd3500 : -13'sd3500;
      end else begin
        r.line_error = -13'sd1;
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (!bits[i]) begin
          wsum += (cur_mode == lsce_pkg::MODE_LINEAR) ? lin_w[i] : sym_w[i];
          nblack++;
        end
      end
      // int division truncates toward zero
      pos = wsum / nblack;
      if (cur_mode == lsce_pkg::MODE_LINEAR) begin
        pos -= CENTRE_OFS;
        dir_positive = (pos > 0);
      end
      r.line_error = pos[12:0];
    end
    return r;
  endfunction

  // Random pattern: mostly a short black run, sometimes lost, noise or all black
  function automatic logic [7:0] make_pattern();
    int kind;
    int w;
    int p;
    logic [7:0] black;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      return lsce_pkg::ALL_WHITE;
    end else if (kind < 27) begin
      return 8'($urandom);
    end else if (kind < 30) begin
      return 8'h00;
    end else begin
      w = $urandom_range(1, 3);
      p = $urandom_range(0, 8 - w);
      black = 8'((1 << w) - 1) << p;
      // flip a stray sensor now and then
      if ($urandom_range(0, 9) == 0) begin
        black ^= 8'(1 << $urandom_range(0, 7));
      end
      return ~black;
    end
  endfunction

  // Driver: send queued patterns in bursts, predict on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        line_pos_q.push_back(predict_line_pos(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 && !quiet_run) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pattern_q.size() > 0) begin
          s_tdata  <= pattern_q.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            gap_left   <= 0;
          end else begin
            burst_left <= $urandom_range(0, 12);
            case ($urandom_range(0, 19))
              0:       gap_left <= $urandom_range(20, 40);
              1, 2, 3,
              4, 5:    gap_left <= $urandom_range(4, 12);
              default: gap_left <= $urandom_range(0, 3);
            endcase
          end
        end else begin
          s_tvalid <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  // Monitor: check result beats in order, stall on a changing pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      ready_cnt <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (line_pos_q.size() == 0) begin
          $error("unexpected result beat: line_error=%0d line_lost=%0b",
                 $signed(m_tdata[12:0]), m_tuser);
          mismatch_count++;
        end else begin
          want = line_pos_q.pop_front();
          if ($signed(m_tdata[12:0]) !== want.line_error) begin
            $error("line_error: expected %0d, got %0d",
                   want.line_error, $signed(m_tdata[12:0]));
            mismatch_count++;
          end
          if (m_tuser !== want.line_lost) begin
            $error("line_lost: expected %0b, got %0b", want.line_lost, m_tuser);
            mismatch_count++;
          end
          if (m_tdata[15:13] !== 3'b000) begin
            $error("tdata_pad: expected 0, got %0d", m_tdata[15:13]);
            mismatch_count++;
          end
        end
      end
      // pick a new stall pattern every so often
      if (ready_cnt == 96) begin
        ready_cnt  <= 0;
        ready_kind <= ready_kind_t'($urandom_range(0, 3));
      end else begin
        ready_cnt <= ready_cnt + 1;
      end
      if (quiet_run) begin
        m_tready <= 1'b1;
      end else begin
        case (ready_kind)
          RDY_ALWAYS:   m_tready <= 1'b1;
          RDY_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
          RDY_PERIODIC: m_tready <= ((ready_cnt % 7) < 3);
          default:      m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Wait until every pattern is sent and every result has come back
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pattern_q.size() != 0 || s_tvalid || line_pos_q.size() != 0);
    repeat (PAD_CYCLES) @(negedge clk);
  endtask

  // Write the mode register while the core is idle
  task automatic write_mode(input logic mode);
    @(posedge clk);
    weight_mode_we    <= 1'b1;
    weight_mode_wdata <= mode;
    cur_mode          = mode;
    @(posedge clk);
    weight_mode_we    <= 1'b0;
    weight_mode_wdata <= 1'b0;
  endtask

  // Queue a block of random patterns and drain it
  task automatic run_random(input int n, input logic quiet);
    quiet_run = quiet;
    for (int k = 0; k < n; k++) begin
      pattern_q.push_back(make_pattern());
    end
    wait_idle();
    quiet_run = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset mode is linear: lost with no history, each lone sensor,
    // hold after positive, all black, centre pair, multi-sensor averages
    pattern_q.push_back(lsce_pkg::ALL_WHITE);
    for (int k = 0; k < 8; k++) begin
      pattern_q.push_back(~8'(1 << k));
    end
    pattern_q.push_back(lsce_pkg::ALL_WHITE);
    pattern_q.push_back(8'h00);
    pattern_q.push_back(lsce_pkg::ALL_WHITE);
    pattern_q.push_back(8'hE7);
    pattern_q.push_back(8'hF8);
    pattern_q.push_back(8'h5A);
    pattern_q.push_back(8'h7F);
    wait_idle();

    // Symmetric mode: lost code, lone sensors, negative truncation
    write_mode(lsce_pkg::MODE_SYMMETRIC);
    pattern_q.push_back(lsce_pkg::ALL_WHITE);
    pattern_q.push_back(8'hFE);
    pattern_q.push_back(8'h7F);
    pattern_q.push_back(8'h00);
    pattern_q.push_back(8'hF8);
    pattern_q.push_back(8'hF4);
    pattern_q.push_back(8'h1F);
    pattern_q.push_back(8'hFC);
    wait_idle();

    // Back to linear: direction held across symmetric mode
    write_mode(lsce_pkg::MODE_LINEAR);
    pattern_q.push_back(lsce_pkg::ALL_WHITE);
    pattern_q.push_back(8'hFE);
    pattern_q.push_back(lsce_pkg::ALL_WHITE);
    wait_idle();

    // Random phases over both modes, two with no idling
    run_random(220, 1'b0);
    write_mode(lsce_pkg::MODE_SYMMETRIC);
    run_random(220, 1'b0);
    write_mode(lsce_pkg::MODE_SYMMETRIC);
    run_random(200, 1'b1);
    write_mode(lsce_pkg::MODE_LINEAR);
    run_random(220, 1'b0);
    write_mode(lsce_pkg::MODE_LINEAR);
    run_random(200, 1'b1);
    write_mode(lsce_pkg::MODE_SYMMETRIC);
    run_random(200, 1'b0);

    if (mismatch_count == 0 && line_pos_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
